>>> hw/rtl/sha256_pkg.sv
// Shared types, round constants and round functions for the SHA-256 hasher.
package sha256_pkg;

  // Command from the front part to the compression back part.
  typedef struct packed {
    logic [511:0] block;
    logic         finish;
  } blk_cmd_t;

  localparam logic [255:0] IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> hw/rtl/sha256_message_hasher.sv
// Top level of the SHA-256 message hasher.
//  channel  | direction | tdata               | tuser        | tlast
//  in_      | in        | data_byte[7:0]      | byte_present | end_of_message
//  out_     | out       | digest_word[31:0]   | word_index   | last_word
// A byte item is taken while the block register is filling and the queue register is empty.
// A full block waits in the queue register; the core then loads it, runs
// 64 rounds on the single shared round unit and does the chain add.
// Padding inserts 9 to 72 bytes after the final item, then
// eight digest items follow, each held while out_tready is low.
// Reset (rst_n low, synchronous) restores the initial hash value.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast   // last_word
);
  import sha256_pkg::*;

  logic     cmd_valid, cmd_ready;
  blk_cmd_t cmd;

  sha256_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .cmd_valid, .cmd_ready, .cmd
  );

  sha256_core u_core (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 3'd7)))
    else $error("last_word out of step with word_index");

  a_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("digest output stopped before the last word");

  a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && !cmd_ready) |=> cmd_valid)
    else $error("queued block dropped");
endmodule

>>> hw/rtl/sha256_front.sv
// Byte packer: fills 64-byte blocks, counts bits and inserts padding.
module sha256_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output sha256_pkg::blk_cmd_t  cmd
);
  import sha256_pkg::*;

  localparam logic [1:0] ST_BYTES = 2'd0;
  localparam logic [1:0] ST_PAD   = 2'd1;
  localparam logic [1:0] ST_LEN   = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic         cmd_valid_r, cmd_valid_nxt;
  logic         finish_r, finish_nxt;

  // A byte is written at pos; a full block goes to the queue register.
  logic         wr_en;
  logic [7:0]   wr_byte;
  logic         accept;

  assign in_tready = (state_r == ST_BYTES) && !cmd_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign cmd_valid = cmd_valid_r;
  assign cmd.block = blk_r;
  assign cmd.finish = finish_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    bits_nxt      = bits_r;
    blk_nxt       = blk_r;
    cmd_valid_nxt = cmd_valid_r && !cmd_ready;
    finish_nxt    = finish_r;
    wr_en         = 1'b0;
    wr_byte       = 8'h00;
    if (!cmd_valid_r || cmd_ready) begin
      unique case (state_r)
        ST_BYTES: begin
          if (accept) begin
            if (in_tuser) begin
              wr_en    = 1'b1;
              wr_byte  = in_tdata;
              bits_nxt = bits_r + 64'd8;
            end
            if (in_tlast) begin
              state_nxt = ST_PAD;
            end
          end
        end
        ST_PAD: begin
          // Marker byte first, then zeros until byte 56.
          wr_en     = 1'b1;
          wr_byte   = PAD_MARK;
          state_nxt = ST_ZERO;
        end
        ST_ZERO: begin
          // Zeros run on into a fresh block when the marker landed past byte 55.
          wr_en = 1'b1;
          if (pos_r == 6'd56) begin
            wr_byte   = bits_r[63:56];
            state_nxt = ST_LEN;
          end else begin
            wr_byte = 8'h00;
          end
        end
        ST_LEN: begin
          wr_en   = 1'b1;
          wr_byte = bits_r[8*(63 - pos_r) +: 8];
        end
        default: state_nxt = ST_BYTES;
      endcase
    end
    if (wr_en) begin
      blk_nxt[8*(63 - pos_r) +: 8] = wr_byte;
      pos_nxt = pos_r + 6'd1;
      if (pos_r == 6'd63) begin
        cmd_valid_nxt = 1'b1;
        finish_nxt    = (state_r == ST_LEN);
        if (state_r == ST_LEN) begin
          state_nxt = ST_BYTES;
          bits_nxt  = 64'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r    <= blk_nxt;
    finish_r <= finish_nxt;
    if (!rst_n) begin
      state_r     <= ST_BYTES;
      pos_r       <= 6'd0;
      bits_r      <= 64'd0;
      cmd_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      bits_r      <= bits_nxt;
      cmd_valid_r <= cmd_valid_nxt;
    end
  end
endmodule

>>> hw/rtl/sha256_core.sv
// Compression engine: one round per cycle, then digest output when finished.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  sha256_pkg::blk_cmd_t  cmd,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,
  output logic [2:0]            out_tuser,
  output logic                  out_tlast
);
  import sha256_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_SUM   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [255:0]      hv_r, hv_nxt;
  logic [31:0]       a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0]       w_r [16];
  logic [5:0]        rnd_r;
  logic [2:0]        oidx_r;
  logic              fin_r;

  logic [31:0] x15, x2, wnew, wcur, s1, ch, t1, s0, mj;

  assign cmd_ready = (state_r == ST_IDLE);

  always_comb begin
    x15  = w_r[1];
    x2   = w_r[14];
    wnew = w_r[0] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3)) + w_r[9]
         + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
    wcur = w_r[0];
    s1   = rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25);
    ch   = (e_r & f_r) ^ (~e_r & g_r);
    t1   = h_r + s1 + ch + round_k(rnd_r) + wcur;
    s0   = rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22);
    mj   = (a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r);
    hv_nxt = hv_r;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cmd_valid) state_nxt = ST_ROUND;
      ST_ROUND: if (rnd_r == 6'd63) state_nxt = ST_SUM;
      ST_SUM: begin
        hv_nxt = {hv_r[255:224] + a_r, hv_r[223:192] + b_r, hv_r[191:160] + c_r,
                  hv_r[159:128] + d_r, hv_r[127:96] + e_r, hv_r[95:64] + f_r,
                  hv_r[63:32] + g_r, hv_r[31:0] + h_r};
        state_nxt = fin_r ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_tready && oidx_r == 3'd7) begin
          state_nxt = ST_IDLE;
          hv_nxt    = IV;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = hv_r[32*(7 - oidx_r) +: 32];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid) begin
      for (int i = 0; i < 16; i++) w_r[i] <= cmd.block[32*(15 - i) +: 32];
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= hv_r;
      fin_r <= cmd.finish;
    end else if (state_r == ST_ROUND) begin
      // Rolling window: word 0 is the current round's schedule word.
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wnew;
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + s0 + mj;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hv_r    <= IV;
      rnd_r   <= 6'd0;
      oidx_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      hv_r    <= hv_nxt;
      rnd_r   <= (state_r == ST_ROUND) ? rnd_r + 6'd1 : 6'd0;
      if (state_r == ST_OUT && out_tready) oidx_r <= oidx_r + 3'd1;
    end
  end
endmodule
